/* hdl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned ATTR_W   = 8;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE    = 8'h20;
  localparam logic [ATTR_W-1:0] DEFAULT_COLOR = 8'd10;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_index;
    logic [CELL_W-1:0]   cell_data;
  } out_word_t;

  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] read_index;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/tcw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/tcw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tcw_pkg::in_word_t push_word_i,
  output logic                   full_o,
  input  wire logic              busy_i,
  output logic                   cmd_valid_o,
  output tcw_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_pop_i
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;

  cmd_t       cmd_new;
  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push_ok;

  // classify
  always_comb begin
    cmd_new            = '0;
    cmd_new.op         = OP_NONE;
    cmd_new.char_code  = push_word_i.char_code;
    unique case (push_word_i.mode)
      MODE_PUT: begin
        cmd_new.op = (push_word_i.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      MODE_CLEAR: begin
        cmd_new.op = OP_CLEAR;
      end
      MODE_READ: begin
        if (32'(push_word_i.read_index) < 32'(CellCount)) begin
          cmd_new.op         = OP_READ;
          cmd_new.read_index = push_word_i.read_index;
        end
      end
      default: begin
        cmd_new.op = OP_NONE;
      end
    endcase
  end

  assign full_o      = (count_q == 2'd2) || busy_i;
  assign push_ok     = push_i && !full_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_ok} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> (count_q != 2'd0))
    else $error("command popped from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("command queue overfilled");

  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |=> (count_q == $past(count_q)) || $past(cmd_pop_i))
    else $error("command taken during clearing pass");
`endif

endmodule

`default_nettype wire

/* hdl/tcw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire tcw_pkg::cmd_t                cmd_i,
  output logic                              cmd_pop_o,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   text_color_i,
  output logic                              busy_o,
  input  wire logic                         pop_i,
  output logic                              empty_o,
  output tcw_pkg::out_word_t                pop_word_o
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AW        = $clog2(CellCount);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CLW       = $clog2(COLUMNS);

  localparam logic [AW-1:0]  LastBase = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0]  LastCell = AW'(CellCount - 1);
  localparam logic [AW-1:0]  ColStep  = AW'(COLUMNS);
  localparam logic [RW-1:0]  LastRow  = RW'(ROWS - 1);
  localparam logic [CLW-1:0] LastCol  = CLW'(COLUMNS - 1);

  state_e             state_q, state_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CLW-1:0]     col_q, col_d;
  logic [AW-1:0]      lin_q, lin_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic [CELL_W-1:0]  data_q, data_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  logic               out_load;
  logic               put_wraps;
  logic               on_last_row;

  assign put_wraps   = (col_q == LastCol);
  assign on_last_row = (row_q == LastRow);

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CellCount)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == LastCell) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUT:     state_d = (put_wraps && on_last_row) ? ST_SCROLL : ST_RESULT;
            OP_NEWLINE: state_d = on_last_row ? ST_SCROLL : ST_RESULT;
            OP_CLEAR:   state_d = ST_CLEAR;
            OP_READ:    state_d = ST_READ_WAIT;
            default:    state_d = ST_RESULT;
          endcase
        end
      end
      ST_READ_WAIT: begin
        state_d = ST_RESULT;
      end
      ST_SCROLL: begin
        if (sweep_q == LastBase) state_d = ST_BLANK;
      end
      ST_BLANK, ST_CLEAR: begin
        if (sweep_q == LastCell) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || pop_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = {text_color_i, SPACE_CODE};
    ram_raddr = AW'(cmd_i.read_index);
    out_load  = 1'b0;
    busy_o    = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        busy_o    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = {DEFAULT_COLOR, SPACE_CODE};
      end
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i && (cmd_i.op == OP_PUT)) begin
          ram_we    = 1'b1;
          ram_waddr = lin_q;
          ram_wdata = {text_color_i, cmd_i.char_code};
        end
      end
      ST_SCROLL: begin
        ram_raddr = sweep_q + ColStep;
        ram_we    = (sweep_q != '0);
        ram_waddr = sweep_q - AW'(1);
        ram_wdata = ram_rdata;
      end
      ST_BLANK, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_RESULT: begin
        out_load = !out_valid_q || pop_i;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // cursor, sweep and result data
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    lin_d   = lin_q;
    data_d  = data_q;
    sweep_d = sweep_q;
    unique case (state_q)
      ST_INIT, ST_BLANK, ST_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
      end
      ST_SCROLL: begin
        if (sweep_q != LastBase) sweep_d = sweep_q + AW'(1);
      end
      ST_READ_WAIT: begin
        data_d = ram_rdata;
      end
      ST_IDLE: begin
        data_d  = '0;
        sweep_d = '0;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUT: begin
              if (put_wraps && on_last_row) begin
                col_d = '0;
                lin_d = LastBase;
              end else begin
                lin_d = lin_q + AW'(1);
                if (put_wraps) begin
                  col_d = '0;
                  row_d = row_q + RW'(1);
                end else begin
                  col_d = col_q + CLW'(1);
                end
              end
            end
            OP_NEWLINE: begin
              col_d = '0;
              if (on_last_row) begin
                lin_d = LastBase;
              end else begin
                row_d = row_q + RW'(1);
                lin_d = lin_q - AW'(col_q) + ColStep;
              end
            end
            OP_CLEAR: begin
              row_d = '0;
              col_d = '0;
              lin_d = '0;
            end
            default: begin
              data_d = '0;
            end
          endcase
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      lin_q       <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      lin_q       <= lin_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (out_load) begin
      out_q.cursor_index <= CURSOR_W'(lin_q);
      out_q.cell_data    <= data_q;
    end
  end

  assign empty_o    = !out_valid_q;
  assign pop_word_o = out_q;

`ifndef SYNTHESIS
  a_lin_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lin_q) == 32'(row_q) * COLUMNS + 32'(col_q))
    else $error("linear cursor out of step with row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
    else $error("cursor outside the screen");

  a_init_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> ($past(sweep_q) == LastCell))
    else $error("clearing pass ended early");

  a_blank_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLANK) |-> (sweep_q >= LastBase))
    else $error("blank fill outside the last row");
`endif

endmodule

`default_nettype wire

/* hdl/text_console_writer_core.sv */
// Channel  | Handshake                    | Word
// ---------+------------------------------+-------------------------------------
// input    | push_i / full_o              | push_word_i: mode, char_code, read_index
// result   | pop_i / empty_o              | pop_word_o: cursor_index, cell_data
// config   | cfg_valid_i / cfg_ready_o    | cfg_text_color_i
//
// A scroll and a clear go one cell per cycle through the single-write-port screen memory.
// After reset a clearing pass fills the screen; full_o stays high while it runs.
// A two-word command queue takes input while the executer or the result register stalls.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire tcw_pkg::in_word_t           push_word_i,
  output logic                             full_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output tcw_pkg::out_word_t               pop_word_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_text_color_i
);

  import tcw_pkg::*;

  logic [ATTR_W-1:0] text_color_q, text_color_d;
  logic              busy;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  assign cfg_ready_o  = 1'b1;
  assign text_color_d = (cfg_valid_i && cfg_ready_o) ? cfg_text_color_i : text_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= DEFAULT_COLOR;
    end else begin
      text_color_q <= text_color_d;
    end
  end

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .push_word_i(push_word_i),
    .full_o     (full_o),
    .busy_i     (busy),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .text_color_i(text_color_q),
    .busy_o      (busy),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .pop_word_o  (pop_word_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELL_COUNT     = COLUMNS * ROWS;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 310;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    in_word_t  word;
    logic [7:0] reps;
    logic       typed;
    out_word_t  want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  in_word_t push_word_i = '0;
  logic full_o;
  logic pop_i = 1'b0;
  logic empty_o;
  out_word_t pop_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ATTR_W-1:0] cfg_text_color_i = '0;

  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  logic [4:0]        cur_row;
  logic [6:0]        cur_col;
  logic [ATTR_W-1:0] text_color_model;

  out_word_t  cursor_cell_q [$];
  drill_row_t drill_q [$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  bit         hold_request = 1'b0;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .push_word_i     (push_word_i),
    .full_o          (full_o),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .pop_word_o      (pop_word_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_text_color_i(cfg_text_color_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void advance_row();
    cur_col = '0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
        screen_model[i] = {text_color_model, SPACE_CODE};
      end
      cur_row = 5'(ROWS - 1);
    end
  endfunction

  function automatic out_word_t console_apply(in_word_t w);
    out_word_t r;
    logic [CURSOR_W-1:0] lin;
    r = '0;
    case (w.mode)
      MODE_PUT: begin
        if (w.char_code == NEWLINE_CODE) begin
          advance_row();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {text_color_model, w.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) advance_row();
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {text_color_model, SPACE_CODE};
        cur_row = '0;
        cur_col = '0;
      end
      MODE_READ: begin
        if (w.read_index < CELL_COUNT) r.cell_data = screen_model[w.read_index];
      end
      default: ;
    endcase
    lin = CURSOR_W'(cur_row * COLUMNS + cur_col);
    r.cursor_index = lin;
    return r;
  endfunction

  function automatic in_word_t random_word(int nl_pct);
    in_word_t w;
    int pick;
    int lin;
    w.mode = MODE_PUT;
    w.char_code = CHAR_W'($urandom_range(8'h20, 8'h7E));
    w.read_index = INDEX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      w.mode = MODE_UNUSED;
      w.char_code = CHAR_W'($urandom_range(0, 255));
    end else if (pick < 3) begin
      w.mode = MODE_CLEAR;
    end else if (pick < 16) begin
      w.mode = MODE_READ;
      lin = cur_row * COLUMNS + cur_col;
      case ($urandom_range(0, 7))
        0, 1, 2, 3: w.read_index = INDEX_W'($urandom_range(lin, (lin > 160) ? lin - 160 : 0));
        7:          w.read_index = INDEX_W'($urandom_range(CELL_COUNT, 2047));
        default:    w.read_index = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
      endcase
    end else if (pick < 16 + nl_pct) begin
      w.char_code = NEWLINE_CODE;
    end else if ($urandom_range(0, 9) == 0) begin
      w.char_code = CHAR_W'($urandom_range(0, 255));
    end
    return w;
  endfunction

  task automatic drill_add(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                           logic [INDEX_W-1:0] idx, int reps, bit typed,
                           logic [CURSOR_W-1:0] cur, logic [CELL_W-1:0] data);
    drill_row_t row;
    row.word = '{mode: mode, char_code: ch, read_index: idx};
    row.reps = 8'(reps);
    row.typed = typed;
    row.want = '{cursor_index: cur, cell_data: data};
    drill_q.push_back(row);
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    out_word_t predicted;
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    push_word_i <= w;
    do @(posedge clk_i); while (full_o);
    predicted = console_apply(w);
    cursor_cell_q.push_back(typed ? want : predicted);
  endtask

  task automatic write_color(logic [ATTR_W-1:0] c);
    cfg_valid_i <= 1'b1;
    cfg_text_color_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    text_color_model = c;
  endtask

  initial begin : receiver
    out_word_t want;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        if (cursor_cell_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual cursor_index=%0d cell_data=%h",
                   $time, pop_word_o.cursor_index, pop_word_o.cell_data);
        end else begin
          want = cursor_cell_q.pop_front();
          if (pop_word_o.cursor_index !== want.cursor_index) begin
            errors++;
            $display("%0t: cursor_index expected %0d actual %0d",
                     $time, want.cursor_index, pop_word_o.cursor_index);
          end
          if (pop_word_o.cell_data !== want.cell_data) begin
            errors++;
            $display("%0t: cell_data expected %h actual %h",
                     $time, want.cell_data, pop_word_o.cell_data);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 13);
      end
      if (stall > 0) begin
        stall--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_seq
    logic [ATTR_W-1:0] phase_color [PHASES];
    int nl_pct [PHASES];
    in_word_t w;
    int n;

    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {DEFAULT_COLOR, SPACE_CODE};
    cur_row = '0;
    cur_col = '0;
    text_color_model = DEFAULT_COLOR;

    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = ATTR_W'($urandom_range(1, 254));
    phase_color[3] = ATTR_W'($urandom_range(1, 254));
    phase_color[4] = DEFAULT_COLOR;
    nl_pct[0] = 4;
    nl_pct[1] = 25;
    nl_pct[2] = 10;
    nl_pct[3] = 40;
    nl_pct[4] = 12;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    drill_add(MODE_READ,   8'h00, 11'd0,    1, 1, 11'd0,  16'h0A20);
    drill_add(MODE_READ,   8'h00, 11'd1999, 1, 1, 11'd0,  16'h0A20);
    drill_add(MODE_READ,   8'hFF, 11'd2047, 1, 1, 11'd0,  16'h0000);
    drill_add(MODE_READ,   8'h00, 11'd2000, 1, 1, 11'd0,  16'h0000);
    drill_add(MODE_UNUSED, 8'hFF, 11'd2047, 1, 1, 11'd0,  16'h0000);
    drill_add(MODE_PUT,    8'h41, 11'd0,    1, 1, 11'd1,  16'h0000);
    drill_add(MODE_READ,   8'h00, 11'd0,    1, 1, 11'd1,  16'h0A41);
    drill_add(MODE_PUT,    8'h00, 11'd0,    1, 1, 11'd2,  16'h0000);
    drill_add(MODE_PUT,    8'hFF, 11'd2047, 1, 1, 11'd3,  16'h0000);
    drill_add(MODE_READ,   8'h00, 11'd2,    1, 1, 11'd3,  16'h0AFF);
    drill_add(MODE_PUT,    NEWLINE_CODE, 11'd0, 1, 1, 11'd80, 16'h0000);
    drill_add(MODE_READ,   8'h00, 11'd3,    1, 1, 11'd80, 16'h0A20);
    drill_add(MODE_PUT,    8'h55, 11'd0,    80, 0, '0, '0);
    drill_add(MODE_READ,   8'h00, 11'd159,  1, 0, '0, '0);
    drill_add(MODE_PUT,    NEWLINE_CODE, 11'd0, 22, 0, '0, '0);
    drill_add(MODE_PUT,    8'h7E, 11'd0,    80, 0, '0, '0);
    drill_add(MODE_READ,   8'h00, 11'd1840, 1, 0, '0, '0);
    drill_add(MODE_READ,   8'h00, 11'd1920, 1, 0, '0, '0);
    drill_add(MODE_PUT,    8'h31, 11'd0,    1, 0, '0, '0);
    drill_add(MODE_PUT,    NEWLINE_CODE, 11'd0, 1, 0, '0, '0);
    drill_add(MODE_READ,   8'h00, 11'd1840, 1, 0, '0, '0);
    drill_add(MODE_CLEAR,  8'h00, 11'd0,    1, 1, 11'd0,  16'h0000);
    drill_add(MODE_READ,   8'h00, 11'd1999, 1, 1, 11'd0,  16'h0A20);
    drill_add(MODE_UNUSED, 8'h00, 11'd0,    1, 1, 11'd0,  16'h0000);

    foreach (drill_q[i]) begin
      repeat (drill_q[i].reps) send_word(drill_q[i].word, drill_q[i].typed, drill_q[i].want);
    end
    push_i <= 1'b0;
    while (cursor_cell_q.size() != 0) @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      write_color(phase_color[p]);
      if (p == 1) hold_request = 1'b1;
      if (p == PHASES - 1) calm = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        w = random_word(nl_pct[p]);
        if (w.mode != MODE_UNUSED) n++;
        send_word(w, 1'b0, '0);
      end
      push_i <= 1'b0;
      while (cursor_cell_q.size() != 0) @(posedge clk_i);
    end

    repeat (30) @(posedge clk_i);
    if (errors == 0 && cursor_cell_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
